@@ hw/rtl/nphs_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nphs_pkg: shared types and constants for the nearest point search
// Angle formats, commands, status codes, the CORDIC arctangent table and the
// request and response bundles of the distance unit.
// ----------------------------------------------------------------------------
package nphs_pkg;

    localparam int ANGLE_BITS   = 16;
    localparam int WORD_W       = 4 * ANGLE_BITS;
    localparam int CORDIC_STEPS = 30;
    localparam int ROOT_STEPS   = 31;

    localparam logic signed [33:0] GAIN_Q30 = 34'sd652032874;
    localparam logic [30:0]        Q30_ONE  = 31'h4000_0000;
    localparam logic [31:0]        HALF_TURN = 32'(1) << (ANGLE_BITS - 1);

    typedef logic [ANGLE_BITS-1:0] t_angle;

    typedef enum logic [1:0] {
        CMD_CLEAR = 2'd0,
        CMD_LOAD  = 2'd1,
        CMD_QUERY = 2'd2,
        CMD_NOP   = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        logic   start;
        t_angle q_az;
        t_angle q_alt;
        t_angle p_az;
        t_angle p_alt;
    } t_dist_req;

    typedef struct packed {
        logic   done;
        t_angle gap;
    } t_dist_rsp;

    // atan(2^-i) on a scale where a full turn is 2^32.
    localparam logic [31:0] ATAN_TURNS [0:31] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
        32'h00000001, 32'h00000000
    };

    // Azimuths are zero-extended, then wrapped to the angle width.
    function automatic t_angle az_to_angle(logic [15:0] v);
        logic [31:0] w;
        w = {16'b0, v};
        return w[ANGLE_BITS-1:0];
    endfunction

    // Altitudes are sign-extended, then wrapped to the angle width.
    function automatic t_angle alt_to_angle(logic [15:0] v);
        logic [31:0] w;
        w = {{16{v[15]}}, v};
        return w[ANGLE_BITS-1:0];
    endfunction

endpackage

@@ hw/rtl/nearest_point_haversine_search_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_point_haversine_search_core: nearest alignment point search
// Keeps a table of sky and mount angle pairs and finds the stored point
// closest to a query direction by haversine great-circle distance.
// ----------------------------------------------------------------------------
// Each input transaction carries a command. Clear empties the table, load
// appends one point (or reports a full table), and query scans the stored
// points in the selected frame and returns the first point at the smallest
// distance, with the distance as a binary angle where half a turn is pi. Every
// input transaction yields exactly one output transaction. Items are handled
// one at a time. Clear, load and no-op items go from acceptance through the
// finish state to the output register. A query reads each stored point in
// turn from the point memory, starts the distance unit on it and waits for
// the distance; the distance unit runs three one-step-per-cycle passes
// (30 CORDIC rotation steps, 31 square root steps, 30 CORDIC vectoring
// steps) with multiply and control states between them. A finished result
// waits in the output register, and the next input transaction is taken
// while it waits. The table memory needs no clearing after reset: the point
// count alone decides which entries are read.
// ----------------------------------------------------------------------------
module nearest_point_haversine_search_core #(
    parameter int MAX_POINTS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_command,
    input  logic        i_frame_select,
    input  logic [15:0] i_query_azimuth,
    input  logic [15:0] i_query_altitude,
    input  logic [15:0] i_sky_azimuth,
    input  logic [15:0] i_sky_altitude,
    input  logic [15:0] i_mount_azimuth,
    input  logic [15:0] i_mount_altitude,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_status,
    output logic [5:0]  o_nearest_index,
    output logic [15:0] o_angular_distance,
    output logic [6:0]  o_point_count
);
    import nphs_pkg::*;

    localparam int CNT_W  = $clog2(MAX_POINTS + 1);
    localparam int ADDR_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

    // Control sequencer: idle, read a point, start its distance, wait for the
    // distance, and hand the finished result to the output register.
    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_READ   = 5'b00010,
        S_START  = 5'b00100,
        S_WAIT   = 5'b01000,
        S_FINISH = 5'b10000
    } t_state;

    t_state r_state;

    logic [CNT_W-1:0]  r_count;
    logic [ADDR_W-1:0] r_idx;
    logic [ADDR_W-1:0] r_best_idx;
    t_angle            r_best_dist;
    logic              r_found;
    logic              r_frame;
    t_angle            r_qaz, r_qalt;

    // Result of the item in progress, waiting for the output register.
    t_status     r_res_status;
    logic [5:0]  r_res_idx;
    logic [15:0] r_res_dist;

    logic        r_out_valid;
    logic [1:0]  r_out_status;
    logic [5:0]  r_out_idx;
    logic [15:0] r_out_dist;
    logic [6:0]  r_out_count;

    logic              w_accept, w_out_take, w_out_free, w_full, w_last, w_better;
    t_cmd              w_cmd;
    logic [WORD_W-1:0] w_wr_data, w_rd_data;
    logic              w_wr_en;
    t_dist_req         w_req;
    t_dist_rsp         w_rsp;
    logic [31:0]       w_best_idx32, w_best_dist32, w_count32;

    assign w_accept   = i_valid && !o_stall;
    assign w_out_take = r_out_valid && !i_stall;
    assign w_out_free = !r_out_valid || !i_stall;
    assign w_cmd      = t_cmd'(i_command);
    assign w_full     = (r_count >= CNT_W'(MAX_POINTS));
    assign w_last     = ((CNT_W'(r_idx) + CNT_W'(1)) == r_count);
    assign w_better   = !r_found || (w_rsp.gap < r_best_dist);
    assign w_wr_en    = w_accept && (w_cmd == CMD_LOAD) && !w_full;
    assign w_wr_data  = {az_to_angle(i_sky_azimuth), alt_to_angle(i_sky_altitude),
                         az_to_angle(i_mount_azimuth), alt_to_angle(i_mount_altitude)};

    nphs_point_mem #(
        .DEPTH (MAX_POINTS),
        .ADDR_W(ADDR_W)
    ) u_mem (
        .i_clk    (i_clk),
        .i_wr_en  (w_wr_en),
        .i_wr_addr(r_count[ADDR_W-1:0]),
        .i_wr_data(w_wr_data),
        .i_rd_en  (r_state == S_READ),
        .i_rd_addr(r_idx),
        .o_rd_data(w_rd_data)
    );

    // The stored word holds sky azimuth, sky altitude, mount azimuth and
    // mount altitude from the top down; the query frame picks one pair.
    always_comb begin
        w_req.start = (r_state == S_START);
        w_req.q_az  = r_qaz;
        w_req.q_alt = r_qalt;
        if (r_frame) begin
            w_req.p_az  = w_rd_data[4*ANGLE_BITS-1:3*ANGLE_BITS];
            w_req.p_alt = w_rd_data[3*ANGLE_BITS-1:2*ANGLE_BITS];
        end else begin
            w_req.p_az  = w_rd_data[2*ANGLE_BITS-1:ANGLE_BITS];
            w_req.p_alt = w_rd_data[ANGLE_BITS-1:0];
        end
    end

    nphs_dist_unit u_dist (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (w_req),
        .o_rsp  (w_rsp)
    );

    assign w_best_idx32  = 32'(w_better ? r_idx : r_best_idx);
    assign w_best_dist32 = 32'(w_better ? w_rsp.gap : r_best_dist);
    assign w_count32     = 32'(r_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // The finish step refills the output register itself.
            if (w_out_take && (r_state != S_FINISH)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_res_idx <= '0;
                        case (w_cmd)
                            CMD_CLEAR: begin
                                r_count      <= '0;
                                r_res_status <= STAT_OK;
                                r_res_dist   <= '0;
                                r_state      <= S_FINISH;
                            end
                            CMD_LOAD: begin
                                r_res_dist <= '0;
                                r_state    <= S_FINISH;
                                if (w_full) begin
                                    r_res_status <= STAT_FULL;
                                end else begin
                                    r_res_status <= STAT_OK;
                                    r_count      <= r_count + CNT_W'(1);
                                end
                            end
                            CMD_QUERY: begin
                                if (r_count == '0) begin
                                    r_res_status <= STAT_EMPTY;
                                    r_res_dist   <= HALF_TURN[15:0];
                                    r_state      <= S_FINISH;
                                end else begin
                                    r_res_status <= STAT_OK;
                                    r_qaz   <= az_to_angle(i_query_azimuth);
                                    r_qalt  <= alt_to_angle(i_query_altitude);
                                    r_frame <= i_frame_select;
                                    r_idx   <= '0;
                                    r_found <= 1'b0;
                                    r_state <= S_READ;
                                end
                            end
                            CMD_NOP: begin
                                r_res_status <= STAT_OK;
                                r_res_dist   <= '0;
                                r_state      <= S_FINISH;
                            end
                            default: begin
                                r_res_status <= STAT_OK;
                                r_res_dist   <= '0;
                                r_state      <= S_FINISH;
                            end
                        endcase
                    end
                end
                S_READ: begin
                    r_state <= S_START;
                end
                S_START: begin
                    r_state <= S_WAIT;
                end
                S_WAIT: begin
                    if (w_rsp.done) begin
                        // Strict less-than keeps the earliest point on a tie.
                        r_found     <= 1'b1;
                        r_best_idx  <= w_best_idx32[ADDR_W-1:0];
                        r_best_dist <= w_best_dist32[ANGLE_BITS-1:0];
                        if (w_last) begin
                            r_res_idx  <= w_best_idx32[5:0];
                            r_res_dist <= w_best_dist32[15:0];
                            r_state    <= S_FINISH;
                        end else begin
                            r_idx   <= r_idx + ADDR_W'(1);
                            r_state <= S_READ;
                        end
                    end
                end
                S_FINISH: begin
                    if (w_out_free) begin
                        r_out_valid  <= 1'b1;
                        r_out_status <= r_res_status;
                        r_out_idx    <= r_res_idx;
                        r_out_dist   <= r_res_dist;
                        r_out_count  <= w_count32[6:0];
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_stall            = (r_state != S_IDLE);
    assign o_valid            = r_out_valid;
    assign o_status           = r_out_status;
    assign o_nearest_index    = r_out_idx;
    assign o_angular_distance = r_out_dist;
    assign o_point_count      = r_out_count;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_POINTS))
        else $error("point count above table size");

    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rsp.done |-> (r_state == S_WAIT))
        else $error("distance result outside of a scan");

    a_scan_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_START) |-> (CNT_W'(r_idx) < r_count))
        else $error("scan reads an entry beyond the point count");

endmodule

@@ hw/rtl/nphs_point_mem.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nphs_point_mem: alignment point table
// One synchronous memory holding the sky and mount pairs of each point, with
// one write port and one registered read port.
// ----------------------------------------------------------------------------
module nphs_point_mem #(
    parameter int DEPTH  = 64,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                      i_clk,
    input  logic                      i_wr_en,
    input  logic [ADDR_W-1:0]         i_wr_addr,
    input  logic [nphs_pkg::WORD_W-1:0] i_wr_data,
    input  logic                      i_rd_en,
    input  logic [ADDR_W-1:0]         i_rd_addr,
    output logic [nphs_pkg::WORD_W-1:0] o_rd_data
);
    import nphs_pkg::*;

    logic [WORD_W-1:0] r_mem [0:DEPTH-1];
    logic [WORD_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ hw/rtl/nphs_cordic_rot.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nphs_cordic_rot: iterative CORDIC rotation lane
// Folds a 32-bit binary angle to the nearest quadrant axis, then rotates one
// micro-step per cycle and maps the result back to cosine and sine in Q1.30.
// ----------------------------------------------------------------------------
module nphs_cordic_rot (
    input  logic               i_clk,
    input  logic               i_load,
    input  logic               i_step,
    input  logic [4:0]         i_iter,
    input  logic [31:0]        i_angle,
    output logic signed [33:0] o_cos,
    output logic signed [33:0] o_sin
);
    import nphs_pkg::*;

    logic signed [33:0] r_x, r_y, r_z;
    logic [1:0]         r_q;
    logic [31:0]        w_sum, w_u;
    logic [1:0]         w_q;
    logic signed [33:0] w_dx, w_dy, w_atan;

    assign w_sum  = i_angle + 32'h2000_0000;
    assign w_q    = w_sum[31:30];
    assign w_u    = i_angle - {w_q, 30'b0};
    assign w_dx   = r_y >>> i_iter;
    assign w_dy   = r_x >>> i_iter;
    assign w_atan = $signed({2'b0, ATAN_TURNS[i_iter]});

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_x <= GAIN_Q30;
            r_y <= '0;
            r_z <= $signed({{2{w_u[31]}}, w_u});
            r_q <= w_q;
        end else if (i_step) begin
            if (r_z >= 0) begin
                r_x <= r_x - w_dx;
                r_y <= r_y + w_dy;
                r_z <= r_z - w_atan;
            end else begin
                r_x <= r_x + w_dx;
                r_y <= r_y - w_dy;
                r_z <= r_z + w_atan;
            end
        end
    end

    always_comb begin
        case (r_q)
            2'd0: begin
                o_cos = r_x;
                o_sin = r_y;
            end
            2'd1: begin
                o_cos = -r_y;
                o_sin = r_x;
            end
            2'd2: begin
                o_cos = -r_x;
                o_sin = -r_y;
            end
            default: begin
                o_cos = r_y;
                o_sin = -r_x;
            end
        endcase
    end

endmodule

@@ hw/rtl/nphs_dist_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nphs_dist_unit: iterative haversine distance unit
// Four rotation lanes give the half-angle sines and the altitude cosines,
// two bit-serial roots follow, and a vectoring pass yields the angle.
// ----------------------------------------------------------------------------
module nphs_dist_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  nphs_pkg::t_dist_req i_req,
    output nphs_pkg::t_dist_rsp o_rsp
);
    import nphs_pkg::*;

    typedef enum logic [8:0] {
        D_IDLE  = 9'b000000001,
        D_ROT   = 9'b000000010,
        D_MUL1  = 9'b000000100,
        D_MUL2  = 9'b000001000,
        D_HSUM  = 9'b000010000,
        D_ROOT  = 9'b000100000,
        D_VLOAD = 9'b001000000,
        D_VEC   = 9'b010000000,
        D_DONE  = 9'b100000000
    } t_dstate;

    t_dstate r_state, n_state;
    logic [4:0] r_iter;

    t_angle      w_dlat, w_dlon;
    logic [31:0] w_ang_lat, w_ang_lon, w_ang_q, w_ang_p;
    logic        w_load, w_step;
    logic signed [33:0] w_lat_cos, w_lat_sin, w_lon_cos, w_lon_sin;
    logic signed [33:0] w_q_cos, w_q_sin, w_p_cos, w_p_sin;

    assign w_dlat    = i_req.p_alt - i_req.q_alt;
    assign w_dlon    = i_req.p_az - i_req.q_az;
    assign w_ang_lat = {1'b0, w_dlat, {(31 - ANGLE_BITS){1'b0}}};
    assign w_ang_lon = {1'b0, w_dlon, {(31 - ANGLE_BITS){1'b0}}};
    assign w_ang_q   = {i_req.q_alt, {(32 - ANGLE_BITS){1'b0}}};
    assign w_ang_p   = {i_req.p_alt, {(32 - ANGLE_BITS){1'b0}}};
    assign w_load    = i_req.start && (r_state == D_IDLE);
    assign w_step    = (r_state == D_ROT);

    nphs_cordic_rot u_lat (
        .i_clk(i_clk), .i_load(w_load), .i_step(w_step), .i_iter(r_iter),
        .i_angle(w_ang_lat), .o_cos(w_lat_cos), .o_sin(w_lat_sin)
    );
    nphs_cordic_rot u_lon (
        .i_clk(i_clk), .i_load(w_load), .i_step(w_step), .i_iter(r_iter),
        .i_angle(w_ang_lon), .o_cos(w_lon_cos), .o_sin(w_lon_sin)
    );
    nphs_cordic_rot u_alt_q (
        .i_clk(i_clk), .i_load(w_load), .i_step(w_step), .i_iter(r_iter),
        .i_angle(w_ang_q), .o_cos(w_q_cos), .o_sin(w_q_sin)
    );
    nphs_cordic_rot u_alt_p (
        .i_clk(i_clk), .i_load(w_load), .i_step(w_step), .i_iter(r_iter),
        .i_angle(w_ang_p), .o_cos(w_p_cos), .o_sin(w_p_sin)
    );

    // Products of the trig terms, one register level after each multiply.
    logic signed [31:0] w_sl, w_so, w_c1, w_c2;
    logic signed [63:0] w_lat_sq, w_lon_sq, w_cc_full;
    logic signed [64:0] w_prod_full;
    logic [31:0]        r_slat2, r_slon2;
    logic signed [31:0] r_cc;
    logic signed [32:0] r_prod;
    logic signed [34:0] w_hsum;
    logic [30:0]        w_h, w_hc;

    assign w_sl        = w_lat_sin[31:0];
    assign w_so        = w_lon_sin[31:0];
    assign w_c1        = w_q_cos[31:0];
    assign w_c2        = w_p_cos[31:0];
    assign w_lat_sq    = w_sl * w_sl;
    assign w_lon_sq    = w_so * w_so;
    assign w_cc_full   = w_c1 * w_c2;
    assign w_prod_full = r_cc * $signed({1'b0, r_slon2});
    assign w_hsum      = $signed({3'b0, r_slat2}) + 35'(r_prod);

    always_comb begin
        if (w_hsum < 0) begin
            w_h = '0;
        end else if (w_hsum > $signed({4'b0, Q30_ONE})) begin
            w_h = Q30_ONE;
        end else begin
            w_h = w_hsum[30:0];
        end
    end
    assign w_hc = Q30_ONE - w_h;

    // Two floor square roots, computed bit-serially side by side.
    logic [61:0] r_v0, r_v1, r_res0, r_res1, r_one;
    logic [61:0] w_t0, w_t1;

    assign w_t0 = r_res0 + r_one;
    assign w_t1 = r_res1 + r_one;

    // Vectoring pass.
    logic signed [33:0] r_vx, r_vy, r_vz;
    logic signed [33:0] w_vdx, w_vdy, w_vatan;
    logic [30:0]        w_zc;
    logic [32:0]        w_round;

    assign w_vdx   = r_vy >>> r_iter;
    assign w_vdy   = r_vx >>> r_iter;
    assign w_vatan = $signed({2'b0, ATAN_TURNS[r_iter]});

    always_comb begin
        if (r_vz < 0) begin
            w_zc = '0;
        end else if (r_vz > $signed({3'b0, Q30_ONE})) begin
            w_zc = Q30_ONE;
        end else begin
            w_zc = r_vz[30:0];
        end
    end
    assign w_round = {1'b0, w_zc, 1'b0} + (33'(1) << (31 - ANGLE_BITS));

    always_comb begin
        n_state = r_state;
        case (r_state)
            D_IDLE:  if (i_req.start) n_state = D_ROT;
            D_ROT:   if (r_iter == 5'(CORDIC_STEPS - 1)) n_state = D_MUL1;
            D_MUL1:  n_state = D_MUL2;
            D_MUL2:  n_state = D_HSUM;
            D_HSUM:  n_state = D_ROOT;
            D_ROOT:  if (r_iter == 5'(ROOT_STEPS - 1)) n_state = D_VLOAD;
            D_VLOAD: n_state = D_VEC;
            D_VEC:   if (r_iter == 5'(CORDIC_STEPS - 1)) n_state = D_DONE;
            D_DONE:  n_state = D_IDLE;
            default: n_state = D_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
            r_iter  <= '0;
        end else begin
            r_state <= n_state;
            if ((r_state == D_ROT || r_state == D_ROOT || r_state == D_VEC)
                && n_state == r_state) begin
                r_iter <= r_iter + 5'd1;
            end else begin
                r_iter <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            D_MUL1: begin
                r_slat2 <= w_lat_sq[61:30];
                r_slon2 <= w_lon_sq[61:30];
                r_cc    <= w_cc_full[61:30];
            end
            D_MUL2: begin
                r_prod <= w_prod_full[62:30];
            end
            D_HSUM: begin
                r_v1   <= 62'({w_h, 30'b0});
                r_v0   <= 62'({w_hc, 30'b0});
                r_res0 <= '0;
                r_res1 <= '0;
                r_one  <= 62'(1) << 60;
            end
            D_ROOT: begin
                if (r_v0 >= w_t0) begin
                    r_v0   <= r_v0 - w_t0;
                    r_res0 <= (r_res0 >> 1) + r_one;
                end else begin
                    r_res0 <= r_res0 >> 1;
                end
                if (r_v1 >= w_t1) begin
                    r_v1   <= r_v1 - w_t1;
                    r_res1 <= (r_res1 >> 1) + r_one;
                end else begin
                    r_res1 <= r_res1 >> 1;
                end
                r_one <= r_one >> 2;
            end
            D_VLOAD: begin
                r_vx <= $signed(r_res0[33:0]);
                r_vy <= $signed(r_res1[33:0]);
                r_vz <= '0;
            end
            D_VEC: begin
                if (r_vy >= 0) begin
                    r_vx <= r_vx + w_vdx;
                    r_vy <= r_vy - w_vdy;
                    r_vz <= r_vz + w_vatan;
                end else begin
                    r_vx <= r_vx - w_vdx;
                    r_vy <= r_vy + w_vdy;
                    r_vz <= r_vz - w_vatan;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_rsp.done = (r_state == D_DONE);
    assign o_rsp.gap  = w_round[31:32-ANGLE_BITS];

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> (r_state == D_IDLE))
        else $error("distance unit started while busy");

    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.done |=> !o_rsp.done)
        else $error("distance done held longer than one cycle");

    a_dist_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.done |-> (32'(o_rsp.gap) <= HALF_TURN))
        else $error("distance above half a turn");

endmodule
